// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the autotile coder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NAC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("autotile check failed");

// The consequent must hold in the cycle after the antecedent.
`define NAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("autotile check failed");

`endif

// File: rtl/core/nac_pkg.sv
// ----------------------------------------------------------------------------
// Autotile coder package
// Shared constants, codes, types and the mask to tile code mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package nac_pkg;

  localparam int MAX_WIDTH_DEF    = 256;
  localparam int TERRAIN_BITS_DEF = 5;

  localparam int POS_W      = 8;
  localparam int H_W        = POS_W + 1;
  localparam int TILE_W     = 6;
  localparam int MAX_ROWS   = 256;
  localparam int NUM_SLOTS  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_DATA_W-1:0] MAP_WIDTH_RST  = 9'd64;
  localparam logic [CFG_DATA_W-1:0] MAP_HEIGHT_RST = 9'd64;

  localparam int SIDE_UP    = 0;
  localparam int SIDE_RIGHT = 1;
  localparam int SIDE_DOWN  = 2;
  localparam int SIDE_LEFT  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH  = 2'd0,
    REG_MAP_HEIGHT = 2'd1,
    REG_REVEAL_ALL = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SLOT_0 = 2'd0,
    SLOT_1 = 2'd1,
    SLOT_2 = 2'd2
  } slot_e;

  // Positions in the neighborhood window handed from the line store to the emitter.
  typedef enum logic [2:0] {
    WIN_CUR     = 3'd0,
    WIN_LEFT1   = 3'd1,
    WIN_LEFT2   = 3'd2,
    WIN_UPLEFT  = 3'd3,
    WIN_UP      = 3'd4,
    WIN_UPRIGHT = 3'd5,
    WIN_UP2     = 3'd6
  } win_e;

  localparam int WIN_CNT = 7;

  // Results still owed for the item in the work stage, listed from last released to first.
  typedef struct packed {
    logic own;
    logic left;
    logic above;
  } pend_t;

  localparam logic [3:0] PERM_MAP [16] = '{
    4'd10, 4'd6, 4'd11, 4'd7, 4'd14, 4'd2, 4'd15, 4'd3,
    4'd9,  4'd5, 4'd8,  4'd4, 4'd13, 4'd1, 4'd12, 4'd0
  };

  function automatic logic [TILE_W-1:0] tile_of_mask(logic [3:0] mask);
    logic [3:0] v;
    v = PERM_MAP[mask];
    return {v[3:2], 2'b00, v[1:0]};
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/nac_intf.sv
// ----------------------------------------------------------------------------
// Autotile coder channels
// Valid/ready channels for map cells, tile results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface nac_cell_if import nac_pkg::*; #(
  parameter int TERRAIN_BITS = TERRAIN_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [TERRAIN_BITS-1:0] terrain_kind;
  logic                    cell_seen;

  modport source (output valid, terrain_kind, cell_seen, input ready);
  modport sink (input valid, terrain_kind, cell_seen, output ready);
endinterface

interface nac_tile_if import nac_pkg::*;;
  logic              valid;
  logic              ready;
  logic [TILE_W-1:0] tile_code;
  logic [POS_W-1:0]  cell_col;
  logic [POS_W-1:0]  cell_row;
  logic              run_last;
  logic              frame_done;

  modport source (output valid, tile_code, cell_col, cell_row, run_last, frame_done,
                  input ready);
  modport sink (input valid, tile_code, cell_col, cell_row, run_last, frame_done,
                output ready);
endinterface

interface nac_cfg_if import nac_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/neighbor_autotile_code.sv
// ----------------------------------------------------------------------------
// Neighbor autotile coder
// Map cells enter in raster order on cell_i; each one below the first row
// releases the tile code of the cell above it, and cells of the last row are
// released as their right neighbor arrives (the last cell of the frame with
// itself). Results leave on tile_o with their column, row, a last-of-item
// flag and a frame-end flag. Geometry and reveal mode are to be written on
// cfg_i only while no item is in flight; the block itself does not enforce
// this. Throughput: one item per cycle while each item owes at most one
// result and tile_o does not stall; an item of the last row owes up to three
// results and holds the input until its results beyond the first have moved
// on, as the output register takes one result per cycle while tile_o is ready.
// The line store is a three-bank memory with two read ports per bank, read
// when the item is accepted. Reset clears the position counters, the pending
// results and the output valid flag; the line store is not cleared. When
// tile_o stalls, the output register holds its result, one further item waits
// in the work stage, and cell_i.ready drops until its results have moved on.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module neighbor_autotile_code import nac_pkg::*; #(
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int TERRAIN_BITS = TERRAIN_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  nac_cfg_if.sink   cfg_i,
  nac_cell_if.sink  cell_i,
  nac_tile_if.source tile_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int EW = TERRAIN_BITS + 1;

  logic [WW-1:0]  eff_w;
  logic [H_W-1:0] eff_h;
  logic           reveal;

  logic [CW-1:0]    col_q;
  logic [CW-1:0]    col_d;
  logic [POS_W-1:0] row_q;
  logic [POS_W-1:0] row_d;
  slot_e            slot_q;
  slot_e            slot_d;

  logic                           accept;
  logic                           emit_ready;
  logic [WW-1:0]                  col_nx;
  logic [H_W-1:0]                 row_nx;
  logic                           last_col;
  logic                           last_row;
  logic [EW-1:0]                  entry;
  pend_t                          pend;
  logic [WIN_CNT-1:0][EW-1:0]     win;

  nac_cfg_regs #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .eff_w_o  (eff_w),
    .eff_h_o  (eff_h),
    .reveal_o (reveal)
  );

  assign cell_i.ready = emit_ready;
  assign accept       = cell_i.valid && cell_i.ready;
  assign entry        = {cell_i.cell_seen, cell_i.terrain_kind};

  assign col_nx   = {1'b0, col_q} + WW'(1);
  assign row_nx   = {1'b0, row_q} + H_W'(1);
  assign last_col = col_nx >= eff_w;
  assign last_row = row_nx >= eff_h;

  assign pend.above = row_q != '0;
  assign pend.left  = last_row && (col_q != '0);
  assign pend.own   = last_row && last_col;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    slot_d = slot_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        if (last_row) begin
          row_d  = '0;
          slot_d = SLOT_0;
        end else begin
          row_d = row_q + POS_W'(1);
          unique case (slot_q)
            SLOT_0:  slot_d = SLOT_1;
            SLOT_1:  slot_d = SLOT_2;
            default: slot_d = SLOT_0;
          endcase
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= SLOT_0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

  nac_window #(
    .MAX_WIDTH    (MAX_WIDTH),
    .TERRAIN_BITS (TERRAIN_BITS)
  ) u_window (
    .clk_i   (clk_i),
    .load_i  (accept),
    .col_i   (col_q),
    .slot_i  (slot_q),
    .entry_i (entry),
    .win_o   (win)
  );

  nac_emit #(
    .MAX_WIDTH    (MAX_WIDTH),
    .TERRAIN_BITS (TERRAIN_BITS)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .col_i        (col_q),
    .row_i        (row_q),
    .pend_i       (pend),
    .eff_w_i      (eff_w),
    .eff_h_i      (eff_h),
    .reveal_i     (reveal),
    .win_i        (win),
    .load_ready_o (emit_ready),
    .tile_o       (tile_o)
  );

  `NAC_ASSERT_NOW(a_row0_slot0, clk_i, rst_ni, row_q == '0, slot_q == SLOT_0)
  `NAC_ASSERT_NEXT(a_col_wraps, clk_i, rst_ni, accept && last_col, col_q == '0)

endmodule

`default_nettype wire

// File: rtl/core/nac_row_bank.sv
// ----------------------------------------------------------------------------
// Row bank
// One row of the line store: one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module nac_row_bank #(
  parameter int DEPTH  = 256,
  parameter int DATA_W = 6
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [DATA_W-1:0]        rdata_a_o,
  output logic      [DATA_W-1:0]        rdata_b_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_a_q;
  logic [DATA_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// File: rtl/core/nac_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Map geometry and reveal mode, with the geometry clamped to its legal range.
// ----------------------------------------------------------------------------
`default_nettype none

module nac_cfg_regs import nac_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  nac_cfg_if.sink                             cfg_i,
  output logic      [$clog2(MAX_WIDTH):0]     eff_w_o,
  output logic      [H_W-1:0]                 eff_h_o,
  output logic                                reveal_o
);

  localparam int WW = $clog2(MAX_WIDTH) + 1;

  logic [CFG_DATA_W-1:0] map_width_q;
  logic [CFG_DATA_W-1:0] map_height_q;
  logic                  reveal_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= MAP_WIDTH_RST;
      map_height_q <= MAP_HEIGHT_RST;
      reveal_q     <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        REG_MAP_WIDTH:  map_width_q  <= cfg_i.data;
        REG_MAP_HEIGHT: map_height_q <= cfg_i.data;
        REG_REVEAL_ALL: reveal_q     <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (map_width_q == '0) begin
      eff_w_o = WW'(1);
    end else if (map_width_q > MAX_WIDTH) begin
      eff_w_o = WW'(MAX_WIDTH);
    end else begin
      eff_w_o = WW'(map_width_q);
    end
  end

  always_comb begin
    if (map_height_q == '0) begin
      eff_h_o = H_W'(1);
    end else if (map_height_q > H_W'(MAX_ROWS)) begin
      eff_h_o = H_W'(MAX_ROWS);
    end else begin
      eff_h_o = map_height_q;
    end
  end

  assign reveal_o = reveal_q;

endmodule

`default_nettype wire

// File: rtl/core/nac_window.sv
// ----------------------------------------------------------------------------
// Neighborhood window
// Three-row line store and the registers that hold the cells around an item.
// ----------------------------------------------------------------------------
`default_nettype none

module nac_window import nac_pkg::*; #(
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int TERRAIN_BITS = TERRAIN_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 load_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]         col_i,
  input  wire slot_e                                slot_i,
  input  wire logic [TERRAIN_BITS:0]                entry_i,
  output logic      [WIN_CNT-1:0][TERRAIN_BITS:0]   win_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = TERRAIN_BITS + 1;

  logic [CW-1:0] addr_b;
  logic [EW-1:0] rd_a [NUM_SLOTS];
  logic [EW-1:0] rd_b [NUM_SLOTS];
  logic [EW-1:0] up;
  logic [EW-1:0] up_right;
  logic [EW-1:0] up2;

  slot_e         slot_q;
  logic [EW-1:0] cur_q;
  logic [EW-1:0] left1_q;
  logic [EW-1:0] left2_q;
  logic [EW-1:0] upleft_q;

  assign addr_b = (col_i == CW'(MAX_WIDTH - 1)) ? col_i : col_i + CW'(1);

  for (genvar b = 0; b < NUM_SLOTS; b++) begin : g_bank
    nac_row_bank #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (EW)
    ) u_bank (
      .clk_i     (clk_i),
      .we_i      (load_i && (slot_i == slot_e'(b))),
      .waddr_i   (col_i),
      .wdata_i   (entry_i),
      .re_i      (load_i),
      .raddr_a_i (col_i),
      .raddr_b_i (addr_b),
      .rdata_a_o (rd_a[b]),
      .rdata_b_o (rd_b[b])
    );
  end

  // Row r lives in bank r mod 3, so the row above is one bank back.
  always_comb begin
    unique case (slot_q)
      SLOT_1: begin
        up       = rd_a[0];
        up_right = rd_b[0];
        up2      = rd_a[2];
      end
      SLOT_2: begin
        up       = rd_a[1];
        up_right = rd_b[1];
        up2      = rd_a[0];
      end
      default: begin
        up       = rd_a[2];
        up_right = rd_b[2];
        up2      = rd_a[1];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q   <= slot_i;
      cur_q    <= entry_i;
      left1_q  <= cur_q;
      left2_q  <= left1_q;
      upleft_q <= up;
    end
  end

  always_comb begin
    win_o              = '0;
    win_o[WIN_CUR]     = cur_q;
    win_o[WIN_LEFT1]   = left1_q;
    win_o[WIN_LEFT2]   = left2_q;
    win_o[WIN_UPLEFT]  = upleft_q;
    win_o[WIN_UP]      = up;
    win_o[WIN_UPRIGHT] = up_right;
    win_o[WIN_UP2]     = up2;
  end

endmodule

`default_nettype wire

// File: rtl/core/nac_emit.sv
// ----------------------------------------------------------------------------
// Result emitter
// Releases the owed tile codes of one item, one per cycle while the output
// register is empty or tile_o is ready, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nac_emit import nac_pkg::*; #(
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int TERRAIN_BITS = TERRAIN_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               load_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]       col_i,
  input  wire logic [POS_W-1:0]                   row_i,
  input  wire pend_t                              pend_i,
  input  wire logic [$clog2(MAX_WIDTH):0]         eff_w_i,
  input  wire logic [H_W-1:0]                     eff_h_i,
  input  wire logic                               reveal_i,
  input  wire logic [WIN_CNT-1:0][TERRAIN_BITS:0] win_i,
  output logic                                    load_ready_o,
  nac_tile_if.source                              tile_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int EW = TERRAIN_BITS + 1;

  function automatic logic side_bit(logic [EW-1:0] me, logic [EW-1:0] nb,
                                    logic exists, logic reveal);
    logic me_seen;
    logic nb_seen;
    me_seen = me[EW-1] | reveal;
    nb_seen = nb[EW-1] | reveal;
    if (me_seen) begin
      return !exists || (nb[EW-2:0] != me[EW-2:0]) || !nb_seen;
    end
    return exists && nb_seen;
  endfunction

  pend_t            pend_q;
  pend_t            pend_clr;
  pend_t            pend_nx;
  logic [CW-1:0]    col_q;
  logic [POS_W-1:0] row_q;

  logic              out_valid_q;
  logic [TILE_W-1:0] tile_q;
  logic [POS_W-1:0]  col_out_q;
  logic [POS_W-1:0]  row_out_q;
  logic              last_q;
  logic              done_q;

  logic [WW-1:0]    col_ext;
  logic [WW-1:0]    col_nx;
  logic [H_W-1:0]   row_ext;
  logic [H_W-1:0]   row_nx;
  logic [EW-1:0]    me;
  logic [EW-1:0]    nb_up;
  logic [EW-1:0]    nb_right;
  logic [EW-1:0]    nb_down;
  logic [EW-1:0]    nb_left;
  logic [3:0]       has;
  logic [3:0]       mask;
  logic [POS_W-1:0] sel_col;
  logic [POS_W-1:0] sel_row;
  logic             sel_done;
  logic             fire;

  assign col_ext = {1'b0, col_q};
  assign col_nx  = col_ext + WW'(1);
  assign row_ext = {1'b0, row_q};
  assign row_nx  = row_ext + H_W'(1);

  always_comb begin
    pend_clr = '0;
    me       = win_i[WIN_CUR];
    nb_up    = win_i[WIN_UP];
    nb_right = win_i[WIN_CUR];
    nb_down  = win_i[WIN_CUR];
    nb_left  = win_i[WIN_LEFT1];
    has      = '0;
    sel_col  = POS_W'(col_q);
    sel_row  = row_q;
    sel_done = 1'b0;
    priority if (pend_q.above) begin
      pend_clr.above  = 1'b1;
      me              = win_i[WIN_UP];
      nb_up           = win_i[WIN_UP2];
      nb_right        = win_i[WIN_UPRIGHT];
      nb_down         = win_i[WIN_CUR];
      nb_left         = win_i[WIN_UPLEFT];
      has[SIDE_UP]    = row_q > POS_W'(1);
      has[SIDE_RIGHT] = col_nx < eff_w_i;
      has[SIDE_DOWN]  = row_ext < eff_h_i;
      has[SIDE_LEFT]  = col_q != '0;
      sel_row         = row_q - POS_W'(1);
    end else if (pend_q.left) begin
      pend_clr.left   = 1'b1;
      me              = win_i[WIN_LEFT1];
      nb_up           = win_i[WIN_UPLEFT];
      nb_right        = win_i[WIN_CUR];
      nb_left         = win_i[WIN_LEFT2];
      has[SIDE_UP]    = row_q != '0;
      has[SIDE_RIGHT] = col_ext < eff_w_i;
      has[SIDE_DOWN]  = row_nx < eff_h_i;
      has[SIDE_LEFT]  = col_q > CW'(1);
      sel_col         = POS_W'(col_q - CW'(1));
    end else begin
      pend_clr.own    = 1'b1;
      has[SIDE_UP]    = row_q != '0;
      has[SIDE_RIGHT] = col_nx < eff_w_i;
      has[SIDE_DOWN]  = row_nx < eff_h_i;
      has[SIDE_LEFT]  = col_q != '0;
      sel_done        = 1'b1;
    end
  end

  assign mask[SIDE_UP]    = side_bit(me, nb_up, has[SIDE_UP], reveal_i);
  assign mask[SIDE_RIGHT] = side_bit(me, nb_right, has[SIDE_RIGHT], reveal_i);
  assign mask[SIDE_DOWN]  = side_bit(me, nb_down, has[SIDE_DOWN], reveal_i);
  assign mask[SIDE_LEFT]  = side_bit(me, nb_left, has[SIDE_LEFT], reveal_i);

  assign pend_nx      = pend_q & ~pend_clr;
  assign fire         = (pend_q != '0) && (!out_valid_q || tile_o.ready);
  assign load_ready_o = (pend_q == '0) || (fire && (pend_nx == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (load_i) begin
      pend_q <= pend_i;
    end else if (fire) begin
      pend_q <= pend_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      col_q <= col_i;
      row_q <= row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (tile_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      tile_q    <= tile_of_mask(mask);
      col_out_q <= sel_col;
      row_out_q <= sel_row;
      last_q    <= pend_nx == '0;
      done_q    <= sel_done;
    end
  end

  assign tile_o.valid      = out_valid_q;
  assign tile_o.tile_code  = tile_q;
  assign tile_o.cell_col   = col_out_q;
  assign tile_o.cell_row   = row_out_q;
  assign tile_o.run_last   = last_q;
  assign tile_o.frame_done = done_q;

  `NAC_ASSERT_NOW(a_done_is_last, clk_i, rst_ni, out_valid_q && done_q, last_q)
  `NAC_ASSERT_NOW(a_code_gap, clk_i, rst_ni, out_valid_q, tile_q[3:2] == 2'b00)

endmodule

`default_nettype wire
